// File: rtl/stt_pkg.sv
// Shared types and constants of the source text tokenizer.
// Item structs, token kind codes, queue sizing, keyword lookup.
// No dependencies.
`default_nettype none

package stt_pkg;

	localparam int OFFSET_W    = 32;
	localparam int KIND_W      = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [KIND_W-1:0] KIND_END     = 5'd0;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 5'd1;
	localparam logic [KIND_W-1:0] KIND_OPEN    = 5'd2;
	localparam logic [KIND_W-1:0] KIND_CLOSE   = 5'd3;
	localparam logic [KIND_W-1:0] KIND_B1      = 5'd4;
	localparam logic [KIND_W-1:0] KIND_B8      = 5'd5;
	localparam logic [KIND_W-1:0] KIND_B16     = 5'd6;
	localparam logic [KIND_W-1:0] KIND_B32     = 5'd7;
	localparam logic [KIND_W-1:0] KIND_B64     = 5'd8;
	localparam logic [KIND_W-1:0] KIND_D32     = 5'd9;
	localparam logic [KIND_W-1:0] KIND_D64     = 5'd10;
	localparam logic [KIND_W-1:0] KIND_F       = 5'd11;
	localparam logic [KIND_W-1:0] KIND_MUAT    = 5'd12;
	localparam logic [KIND_W-1:0] KIND_STRING  = 5'd13;
	localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd14;
	localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd15;
	localparam logic [KIND_W-1:0] KIND_UNTERM  = 5'd16;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] byte_value;
	} src_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]   token_kind;
		logic [OFFSET_W-1:0] start_offset;
		logic [OFFSET_W-1:0] end_offset;
		logic                last;
	} tok_item_t;

	// up to two tokens from one source byte
	typedef struct packed {
		logic      two;
		tok_item_t tok1;
		tok_item_t tok0;
	} tok_pair_t;

	typedef struct packed {
		logic      push;
		tok_pair_t pair;
	} q_wr_t;

	// word of up to four letters/digits, packed big-endian into 32 bits
	function automatic logic [KIND_W-1:0] kw_kind(input logic [2:0] len,
		input logic [31:0] pfx);
		logic [KIND_W-1:0] k;
		k = KIND_IDENT;
		priority if (len == 3'd2 && pfx == 32'h0000_6231) k = KIND_B1;
		else if (len == 3'd2 && pfx == 32'h0000_6238) k = KIND_B8;
		else if (len == 3'd3 && pfx == 32'h0062_3136) k = KIND_B16;
		else if (len == 3'd3 && pfx == 32'h0062_3332) k = KIND_B32;
		else if (len == 3'd3 && pfx == 32'h0062_3634) k = KIND_B64;
		else if (len == 3'd3 && pfx == 32'h0064_3332) k = KIND_D32;
		else if (len == 3'd3 && pfx == 32'h0064_3634) k = KIND_D64;
		else if (len == 3'd1 && pfx == 32'h0000_0066) k = KIND_F;
		else if (len == 3'd4 && pfx == 32'h6d75_6174) k = KIND_MUAT;
		else k = KIND_IDENT;
		return k;
	endfunction

endpackage

`default_nettype wire

// File: rtl/stt_front.sv
// Front end: per-byte lexer state machine, builds 0..2 tokens per byte.
// Depends on stt_pkg; writes token pairs into stt_queue.
`default_nettype none

module stt_front import stt_pkg::*; #(
	parameter int POSITION_BITS = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      accept,
	input  wire src_item_t src,
	output q_wr_t          wr
);

	localparam int PB = POSITION_BITS;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_POINT  = 8'h2e;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_UNDER  = 8'h5f;

	typedef enum logic [3:0] {
		MODE_IDLE, MODE_SLASH, MODE_LINE, MODE_BLOCK, MODE_BLOCK_STAR,
		MODE_STRING, MODE_DOT, MODE_NUMBER, MODE_WORD, MODE_IDENT
	} mode_t;

	function automatic logic is_space(input logic [7:0] ch);
		return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] ch);
		return ch >= 8'h30 && ch <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] ch);
		return (ch >= 8'h41 && ch <= 8'h5a) || (ch >= 8'h61 && ch <= 8'h7a);
	endfunction

	function automatic tok_item_t mk_tok(input logic [KIND_W-1:0] kind,
		input logic [PB-1:0] s, input logic [PB-1:0] e);
		tok_item_t t;
		t.token_kind   = kind;
		t.start_offset = OFFSET_W'(s);
		t.end_offset   = OFFSET_W'(e);
		t.last         = 1'b0;
		return t;
	endfunction

	mode_t         mode_q, mode_d;
	logic          quote_single_q, quote_single_d;
	logic          seen_point_q, seen_point_d;
	logic [PB-1:0] tok_start_q, tok_start_d;
	logic [PB-1:0] pos_q, pos_d;
	logic [31:0]   prefix_q, prefix_d;
	logic [2:0]    wlen_q, wlen_d;

	logic [7:0]    ch;
	logic [PB-1:0] pos1, start1;
	logic [KIND_W-1:0] wkind;

	// token start classification of the current byte
	mode_t             bt_mode;
	logic              bt_emit;
	logic [KIND_W-1:0] bt_kind;

	logic      do_begin;
	logic      a_v, b_v;
	tok_item_t a_tok, b_tok;

	assign ch     = src.byte_value;
	assign pos1   = pos_q + PB'(1);
	assign start1 = tok_start_q + PB'(1);
	assign wkind  = kw_kind(wlen_q, prefix_q);

	always_comb begin
		bt_mode = MODE_IDLE;
		bt_emit = 1'b0;
		bt_kind = KIND_UNKNOWN;
		priority if (is_space(ch)) begin
			bt_mode = MODE_IDLE;
		end else if (ch == CH_LPAREN) begin
			bt_emit = 1'b1;
			bt_kind = KIND_OPEN;
		end else if (ch == CH_RPAREN || ch == CH_COMMA) begin
			bt_emit = 1'b1;
			bt_kind = KIND_CLOSE;
		end else if (ch == CH_SLASH) begin
			bt_mode = MODE_SLASH;
		end else if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
			bt_mode = MODE_STRING;
		end else if (is_digit(ch)) begin
			bt_mode = MODE_NUMBER;
		end else if (ch == CH_POINT) begin
			bt_mode = MODE_DOT;
		end else if (is_alpha(ch)) begin
			bt_mode = MODE_WORD;
		end else if (ch == CH_UNDER) begin
			bt_mode = MODE_IDENT;
		end else begin
			bt_emit = 1'b1;
			bt_kind = KIND_UNKNOWN;
		end
	end

	always_comb begin
		mode_d         = mode_q;
		quote_single_d = quote_single_q;
		seen_point_d   = seen_point_q;
		tok_start_d    = tok_start_q;
		pos_d          = pos1;
		prefix_d       = prefix_q;
		wlen_d         = wlen_q;
		do_begin       = 1'b0;
		a_v            = 1'b0;
		a_tok          = mk_tok(KIND_UNKNOWN, tok_start_q, start1);
		b_v            = 1'b0;
		b_tok          = mk_tok(bt_kind, pos_q, pos1);

		if (src.command == CMD_END) begin
			unique case (mode_q)
				MODE_SLASH, MODE_DOT: begin
					a_v = 1'b1;
				end
				MODE_BLOCK, MODE_BLOCK_STAR, MODE_STRING: begin
					a_v   = 1'b1;
					a_tok = mk_tok(KIND_UNTERM, tok_start_q, pos_q);
				end
				MODE_NUMBER: begin
					a_v   = 1'b1;
					a_tok = mk_tok(KIND_NUMBER, tok_start_q, pos_q);
				end
				MODE_WORD: begin
					a_v   = 1'b1;
					a_tok = mk_tok(wkind, tok_start_q, pos_q);
				end
				MODE_IDENT: begin
					a_v   = 1'b1;
					a_tok = mk_tok(KIND_IDENT, tok_start_q, pos_q);
				end
				default: begin
				end
			endcase
			b_v            = 1'b1;
			b_tok          = mk_tok(KIND_END, pos_q, pos_q);
			mode_d         = MODE_IDLE;
			quote_single_d = 1'b0;
			seen_point_d   = 1'b0;
			tok_start_d    = '0;
			pos_d          = '0;
			prefix_d       = '0;
			wlen_d         = '0;
		end else begin
			unique case (mode_q)
				MODE_SLASH: begin
					priority if (ch == CH_SLASH) mode_d = MODE_LINE;
					else if (ch == CH_STAR) mode_d = MODE_BLOCK;
					else begin
						a_v      = 1'b1;
						do_begin = 1'b1;
					end
				end
				MODE_LINE: begin
					if (ch == CH_LF) mode_d = MODE_IDLE;
				end
				MODE_BLOCK: begin
					if (ch == CH_STAR) mode_d = MODE_BLOCK_STAR;
				end
				MODE_BLOCK_STAR: begin
					priority if (ch == CH_SLASH) mode_d = MODE_IDLE;
					else if (ch != CH_STAR) mode_d = MODE_BLOCK;
				end
				MODE_STRING: begin
					if (ch == (quote_single_q ? CH_SQUOTE : CH_DQUOTE)) begin
						a_v    = 1'b1;
						a_tok  = mk_tok(KIND_STRING, tok_start_q, pos1);
						mode_d = MODE_IDLE;
					end
				end
				MODE_DOT: begin
					if (is_digit(ch)) begin
						mode_d       = MODE_NUMBER;
						seen_point_d = 1'b1;
					end else begin
						a_v      = 1'b1;
						do_begin = 1'b1;
					end
				end
				MODE_NUMBER: begin
					priority if (is_digit(ch)) begin
					end else if (ch == CH_POINT && !seen_point_q) begin
						seen_point_d = 1'b1;
					end else begin
						a_v      = 1'b1;
						a_tok    = mk_tok(KIND_NUMBER, tok_start_q, pos_q);
						do_begin = 1'b1;
					end
				end
				MODE_WORD: begin
					priority if (is_alpha(ch) || is_digit(ch)) begin
						if (wlen_q < 3'd4) begin
							prefix_d = {prefix_q[23:0], ch};
							wlen_d   = wlen_q + 3'd1;
						end else begin
							mode_d = MODE_IDENT;
						end
					end else if (ch == CH_UNDER) begin
						// keyword ends at the underscore, rest is an identifier
						if (wkind != KIND_IDENT) begin
							a_v         = 1'b1;
							a_tok       = mk_tok(wkind, tok_start_q, pos_q);
							tok_start_d = pos_q;
						end
						mode_d = MODE_IDENT;
					end else begin
						a_v      = 1'b1;
						a_tok    = mk_tok(wkind, tok_start_q, pos_q);
						do_begin = 1'b1;
					end
				end
				MODE_IDENT: begin
					if (!is_alpha(ch) && !is_digit(ch) && ch != CH_UNDER) begin
						a_v      = 1'b1;
						a_tok    = mk_tok(KIND_IDENT, tok_start_q, pos_q);
						do_begin = 1'b1;
					end
				end
				default: begin
					do_begin = 1'b1;
				end
			endcase

			if (do_begin) begin
				mode_d      = bt_mode;
				tok_start_d = pos_q;
				b_v         = bt_emit;
				if (bt_mode == MODE_STRING) quote_single_d = (ch == CH_SQUOTE);
				if (bt_mode == MODE_NUMBER) seen_point_d = 1'b0;
				if (bt_mode == MODE_WORD) begin
					prefix_d = {24'd0, ch};
					wlen_d   = 3'd1;
				end
			end
		end
	end

	// pack into queue entry, last flag on the final token
	always_comb begin
		wr.push      = accept && (a_v || b_v);
		wr.pair.two  = a_v && b_v;
		wr.pair.tok0 = a_v ? a_tok : b_tok;
		wr.pair.tok1 = b_tok;
		wr.pair.tok0.last = !(a_v && b_v);
		wr.pair.tok1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_IDLE;
			quote_single_q <= 1'b0;
			seen_point_q   <= 1'b0;
			tok_start_q    <= '0;
			pos_q          <= '0;
			prefix_q       <= '0;
			wlen_q         <= '0;
		end else if (accept) begin
			mode_q         <= mode_d;
			quote_single_q <= quote_single_d;
			seen_point_q   <= seen_point_d;
			tok_start_q    <= tok_start_d;
			pos_q          <= pos_d;
			prefix_q       <= prefix_d;
			wlen_q         <= wlen_d;
		end
	end

	a_end_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && src.command == CMD_END |-> wr.push &&
			(wr.pair.two ? wr.pair.tok1.token_kind : wr.pair.tok0.token_kind) == KIND_END)
		else $error("end command did not queue an end token");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && src.command == CMD_END |=> pos_q == '0 && mode_q == MODE_IDLE)
		else $error("lexer not back at start after end command");

endmodule

`default_nettype wire

// File: rtl/stt_queue.sv
// Short queue of token pairs between lexer front end and output back end.
// Depends on stt_pkg.
`default_nettype none

module stt_queue import stt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire q_wr_t wr,
	input  wire logic  pop,
	output tok_pair_t  head,
	output logic       empty,
	output logic       full
);

	tok_pair_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] count_q;

	assign empty = count_q == '0;
	assign full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign head  = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr.push) entry_q[wptr_q] <= wr.pair;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr.push) wptr_q <= wptr_q + QPTR_W'(1);
			if (pop) rptr_q <= rptr_q + QPTR_W'(1);
			unique case ({wr.push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr.push |-> !full)
		else $error("push into full token queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty token queue");

endmodule

`default_nettype wire

// File: rtl/stt_back.sv
// Back end: splits queued token pairs into single tokens on an output register.
// Depends on stt_pkg; reads the head of stt_queue.
`default_nettype none

module stt_back import stt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire tok_pair_t head,
	input  wire logic      empty,
	output logic           pop,
	output logic           tok_valid,
	input  wire logic      tok_ready,
	output tok_item_t      tok_item
);

	logic      valid_q;
	logic      second_q;
	tok_item_t tok_q;
	logic      load;

	assign load      = !valid_q || tok_ready;
	assign pop       = load && !empty && (!head.two || second_q);
	assign tok_valid = valid_q;
	assign tok_item  = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) second_q <= head.two && !second_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) tok_q <= second_q ? head.tok1 : head.tok0;
	end

	a_second_has_pair: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> !empty && head.two)
		else $error("second token pending without a pair at queue head");

endmodule

`default_nettype wire

// File: rtl/source_text_tokenizer_core.sv
// Top level of the source text tokenizer: byte input, token output.
// Depends on stt_pkg, stt_front, stt_queue, stt_back.
//
// Usage:
//   src channel (src_valid/src_ready/src_item) takes one item per transfer:
//   command 0 carries a source byte, command 1 marks end of input.
//   tok channel (tok_valid/tok_ready/tok_item) delivers tokens in order,
//   each with kind, start and end byte offsets, and last set on the final
//   token caused by one input item.
// Throughput: one input item per cycle while src_ready is high. The lexer
//   state machine in the front end updates on each accepted byte; tokens
//   leave at one per cycle while tok_ready is high, from the back end's
//   output register, so an item giving two tokens occupies it for both.
// Path: a token is written into the queue at the transfer of the byte that
//   completes it, then loaded into the back end's output register, which
//   drives tok_valid.
// Stalls: when tok_ready is low, pairs collect in a four-entry queue;
//   src_ready drops only when that queue is full.
// Reset: arst_n clears the lexer to idle at offset zero and empties the
//   queue and output register. End of input also returns the lexer to offset
//   zero so the next byte starts a new text.
`default_nettype none

module source_text_tokenizer_core import stt_pkg::*; #(
	parameter int POSITION_BITS = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      src_valid,
	output logic           src_ready,
	input  wire src_item_t src_item,
	output logic           tok_valid,
	input  wire logic      tok_ready,
	output tok_item_t      tok_item
);

	q_wr_t     wr;
	tok_pair_t head;
	logic      q_empty, q_full, q_pop;
	logic      src_xfer;

	// front end never waits on anything but queue space
	assign src_ready = !q_full;
	assign src_xfer  = src_valid && src_ready;

	stt_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (src_xfer),
		.src    (src_item),
		.wr     (wr)
	);

	stt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.pop    (q_pop),
		.head   (head),
		.empty  (q_empty),
		.full   (q_full)
	);

	stt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (q_pop),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_item  (tok_item)
	);

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for source_text_tokenizer_core: byte stream in, tokens out.
// Depends on stt_pkg and the tokenizer RTL; it predicts tokens with its own lexer copy.
// Directed texts first, then random well-formed fragments mixed with noise.
`default_nettype none

module tb import stt_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// Nothing moving on either channel for this many cycles means a hang.
	localparam int STALL_LIMIT  = 4000;
	// Tail wait after the last token: covers the queue-plus-register latency.
	localparam int DRAIN_CYCLES = 12;

	localparam logic [7:0] CH_LF         = 8'h0A;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_DQUOTE     = 8'h22;
	localparam logic [7:0] CH_SQUOTE     = 8'h27;
	localparam logic [7:0] CH_LPAREN     = 8'h28;
	localparam logic [7:0] CH_RPAREN     = 8'h29;
	localparam logic [7:0] CH_STAR       = 8'h2A;
	localparam logic [7:0] CH_COMMA      = 8'h2C;
	localparam logic [7:0] CH_POINT      = 8'h2E;
	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

	// Lexer states of the token predictor.
	typedef enum logic [3:0] {
		LX_IDLE, LX_SLASH, LX_LINE, LX_BLOCK, LX_BLOCK_STAR,
		LX_STRING, LX_DOT, LX_NUMBER, LX_WORD, LX_IDENT
	} lex_mode_t;

	logic      clk;
	logic      arst_n;
	logic      src_valid;
	logic      src_ready;
	src_item_t src_item;
	logic      tok_valid;
	logic      tok_ready;
	tok_item_t tok_item;

	source_text_tokenizer_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_item  (tok_item)
	);

	// Predictor state: a private copy of the lexer.
	lex_mode_t   lx_mode;
	bit          quote_single;
	bit          number_has_point;
	logic [31:0] tok_begin;
	logic [31:0] byte_pos;
	string       word_text;      // up to four letters/digits of a word token

	tok_item_t   step_toks[$];       // tokens caused by the item being predicted
	tok_item_t   expected_tokens[$]; // predicted tokens not yet seen on the output
	logic [7:0]  frag_bytes[$];      // bytes of one random text fragment

	string keyword_text[9] = '{"b1", "b8", "b16", "b32", "b64", "d32", "d64", "f", "muat"};

	bit idle_on;        // random gaps on the source side and stalls on the token side
	int failures;
	int items_sent;
	int tokens_checked;
	int texts_ended;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit blank_char(logic [7:0] c);
		return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic bit digit_char(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit letter_char(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic [KIND_W-1:0] word_token_kind(string w);
		case (w)
			"b1":    return KIND_B1;
			"b8":    return KIND_B8;
			"b16":   return KIND_B16;
			"b32":   return KIND_B32;
			"b64":   return KIND_B64;
			"d32":   return KIND_D32;
			"d64":   return KIND_D64;
			"f":     return KIND_F;
			"muat":  return KIND_MUAT;
			default: return KIND_IDENT;
		endcase
	endfunction

	function automatic void lexer_clear();
		lx_mode          = LX_IDLE;
		quote_single     = 1'b0;
		number_has_point = 1'b0;
		tok_begin        = '0;
		byte_pos         = '0;
		word_text        = "";
	endfunction

	function automatic void add_tok(logic [KIND_W-1:0] kind, logic [31:0] s, logic [31:0] e);
		tok_item_t t;
		t.token_kind   = kind;
		t.start_offset = s;
		t.end_offset   = e;
		t.last         = 1'b0;
		step_toks.push_back(t);
	endfunction

	function automatic void word_append(logic [7:0] c);
		word_text = {word_text, " "};
		word_text.putc(word_text.len() - 1, c);
	endfunction

	// First byte of a new token, or a byte seen while between tokens.
	function automatic void open_token(logic [7:0] c, logic [31:0] pos);
		lx_mode   = LX_IDLE;
		tok_begin = pos;
		if (blank_char(c))
			return;
		if (c == CH_LPAREN) begin
			add_tok(KIND_OPEN, pos, pos + 1);
		end else if (c == CH_RPAREN || c == CH_COMMA) begin
			add_tok(KIND_CLOSE, pos, pos + 1);
		end else if (c == CH_SLASH) begin
			lx_mode = LX_SLASH;
		end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
			lx_mode      = LX_STRING;
			quote_single = (c == CH_SQUOTE);
		end else if (digit_char(c)) begin
			lx_mode          = LX_NUMBER;
			number_has_point = 1'b0;
		end else if (c == CH_POINT) begin
			lx_mode = LX_DOT;
		end else if (letter_char(c)) begin
			lx_mode   = LX_WORD;
			word_text = "";
			word_append(c);
		end else if (c == CH_UNDERSCORE) begin
			lx_mode = LX_IDENT;
		end else begin
			add_tok(KIND_UNKNOWN, pos, pos + 1);
		end
	endfunction

	// Works out the tokens one accepted source item causes and queues them.
	function automatic void predict_tokens(src_item_t it);
		logic [31:0]       pos;
		logic [7:0]        c;
		logic [KIND_W-1:0] k;
		tok_item_t         t;
		step_toks.delete();
		pos = byte_pos;
		c   = it.byte_value;
		if (it.command == CMD_END) begin
			// flush whatever token is still open, then the end token
			case (lx_mode)
				LX_SLASH, LX_DOT:
					add_tok(KIND_UNKNOWN, tok_begin, tok_begin + 1);
				LX_BLOCK, LX_BLOCK_STAR, LX_STRING:
					add_tok(KIND_UNTERM, tok_begin, pos);
				LX_NUMBER: add_tok(KIND_NUMBER, tok_begin, pos);
				LX_WORD:   add_tok(word_token_kind(word_text), tok_begin, pos);
				LX_IDENT:  add_tok(KIND_IDENT, tok_begin, pos);
				default: ;
			endcase
			add_tok(KIND_END, pos, pos);
			lexer_clear();
		end else begin
			case (lx_mode)
				LX_SLASH: begin
					if (c == CH_SLASH) begin
						lx_mode = LX_LINE;
					end else if (c == CH_STAR) begin
						lx_mode = LX_BLOCK;
					end else begin
						add_tok(KIND_UNKNOWN, tok_begin, tok_begin + 1);
						open_token(c, pos);
					end
				end
				LX_LINE: begin
					if (c == CH_LF)
						lx_mode = LX_IDLE;
				end
				LX_BLOCK: begin
					if (c == CH_STAR)
						lx_mode = LX_BLOCK_STAR;
				end
				LX_BLOCK_STAR: begin
					if (c == CH_SLASH)
						lx_mode = LX_IDLE;
					else if (c != CH_STAR)
						lx_mode = LX_BLOCK;
				end
				LX_STRING: begin
					if (c == (quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
						add_tok(KIND_STRING, tok_begin, pos + 1);
						lx_mode = LX_IDLE;
					end
				end
				LX_DOT: begin
					if (digit_char(c)) begin
						lx_mode          = LX_NUMBER;
						number_has_point = 1'b1;
					end else begin
						add_tok(KIND_UNKNOWN, tok_begin, tok_begin + 1);
						open_token(c, pos);
					end
				end
				LX_NUMBER: begin
					if (digit_char(c)) begin
					end else if (c == CH_POINT && !number_has_point) begin
						number_has_point = 1'b1;
					end else begin
						add_tok(KIND_NUMBER, tok_begin, pos);
						open_token(c, pos);
					end
				end
				LX_WORD: begin
					if (digit_char(c) || letter_char(c)) begin
						if (word_text.len() < 4)
							word_append(c);
						else
							lx_mode = LX_IDENT;
					end else if (c == CH_UNDERSCORE) begin
						// a keyword stops at the underscore; the rest is an identifier
						k = word_token_kind(word_text);
						if (k != KIND_IDENT) begin
							add_tok(k, tok_begin, pos);
							tok_begin = pos;
						end
						lx_mode = LX_IDENT;
					end else begin
						add_tok(word_token_kind(word_text), tok_begin, pos);
						open_token(c, pos);
					end
				end
				LX_IDENT: begin
					if (!digit_char(c) && !letter_char(c) && c != CH_UNDERSCORE) begin
						add_tok(KIND_IDENT, tok_begin, pos);
						open_token(c, pos);
					end
				end
				default: open_token(c, pos);
			endcase
			byte_pos = pos + 1;
		end
		foreach (step_toks[i]) begin
			t      = step_toks[i];
			t.last = (i == step_toks.size() - 1);
			expected_tokens.push_back(t);
		end
	endfunction

	// Mostly no gap, some short ones, a few long ones.
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	// Drives one item at a falling edge and holds it until the transfer.
	task automatic send_item(src_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0)
			repeat (gap) @(negedge clk);
		src_item  = it;
		src_valid = 1'b1;
		@(posedge clk);
		while (!src_ready)
			@(posedge clk);
		predict_tokens(it);
		items_sent++;
		if (it.command == CMD_END)
			texts_ended++;
		@(negedge clk);
		src_valid = 1'b0;
	endtask

	task automatic send_byte(logic [7:0] c);
		src_item_t it;
		it.command    = CMD_BYTE;
		it.byte_value = c;
		send_item(it);
	endtask

	task automatic send_end(logic [7:0] junk);
		src_item_t it;
		it.command    = CMD_END;
		it.byte_value = junk;
		send_item(it);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	function automatic logic [7:0] rand_word_char();
		case ($urandom_range(0, 3))
			0:       return 8'($urandom_range("0", "9"));
			1:       return 8'($urandom_range("A", "Z"));
			2:       return 8'($urandom_range("a", "z"));
			default: return CH_UNDERSCORE;
		endcase
	endfunction

	function automatic logic [7:0] rand_blank();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? CH_SPACE : 8'(8'h09 + r);
	endfunction

	// One random piece of source text: mostly well-formed tokens, some noise.
	function automatic void build_fragment();
		string      kw;
		int         n;
		logic [7:0] q;
		frag_bytes.delete();
		case ($urandom_range(0, 11))
			0, 1: begin
				kw = keyword_text[$urandom_range(0, 8)];
				for (int i = 0; i < kw.len(); i++)
					frag_bytes.push_back(kw[i]);
				if ($urandom_range(0, 2) == 0)
					frag_bytes.push_back(rand_word_char());
			end
			2: begin
				frag_bytes.push_back(($urandom_range(0, 3) == 0) ? CH_UNDERSCORE :
					8'($urandom_range("a", "z")));
				n = $urandom_range(0, 6);
				repeat (n) frag_bytes.push_back(rand_word_char());
			end
			3: begin
				if ($urandom_range(0, 3) == 0)
					frag_bytes.push_back(CH_POINT);
				n = $urandom_range(1, 4);
				repeat (n) frag_bytes.push_back(8'($urandom_range("0", "9")));
				if ($urandom_range(0, 1) == 1) begin
					frag_bytes.push_back(CH_POINT);
					n = $urandom_range(0, 3);
					repeat (n) frag_bytes.push_back(8'($urandom_range("0", "9")));
				end
			end
			4: begin
				q = ($urandom_range(0, 1) == 1) ? CH_SQUOTE : CH_DQUOTE;
				frag_bytes.push_back(q);
				n = $urandom_range(0, 5);
				repeat (n) frag_bytes.push_back(8'($urandom_range(32, 126)));
				if ($urandom_range(0, 9) != 0)
					frag_bytes.push_back(q);
			end
			5: begin
				frag_bytes.push_back(CH_SLASH);
				frag_bytes.push_back(CH_SLASH);
				n = $urandom_range(0, 6);
				repeat (n) frag_bytes.push_back(8'($urandom_range(0, 255)));
				frag_bytes.push_back(CH_LF);
			end
			6: begin
				frag_bytes.push_back(CH_SLASH);
				frag_bytes.push_back(CH_STAR);
				n = $urandom_range(0, 6);
				// stars and slashes often, to hit the star-then-not-slash paths
				repeat (n) begin
					case ($urandom_range(0, 2))
						0:       frag_bytes.push_back(CH_STAR);
						1:       frag_bytes.push_back(CH_SLASH);
						default: frag_bytes.push_back(8'($urandom_range(0, 255)));
					endcase
				end
				frag_bytes.push_back(CH_STAR);
				frag_bytes.push_back(CH_SLASH);
			end
			7: begin
				case ($urandom_range(0, 2))
					0:       frag_bytes.push_back(CH_LPAREN);
					1:       frag_bytes.push_back(CH_RPAREN);
					default: frag_bytes.push_back(CH_COMMA);
				endcase
			end
			8: frag_bytes.push_back(($urandom_range(0, 1) == 1) ? CH_POINT : CH_SLASH);
			9: begin
				n = $urandom_range(1, 3);
				repeat (n) frag_bytes.push_back(8'($urandom_range(0, 255)));
			end
			default: frag_bytes.push_back(rand_blank());
		endcase
		// usually a blank between fragments; no blank tests token adjacency
		if ($urandom_range(0, 9) < 6)
			frag_bytes.push_back(rand_blank());
	endfunction

	task automatic send_fragment();
		build_fragment();
		foreach (frag_bytes[i])
			send_byte(frag_bytes[i]);
		if ($urandom_range(0, 29) == 0)
			send_end(8'($urandom_range(0, 255)));
	endtask

	// Returns at a falling edge so the next item is driven there.
	task automatic wait_for_drain();
		while (expected_tokens.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Short texts aimed at each token kind and each odd corner.
	task automatic test_directed();
		// NUL and 0xFF as unknown bytes, open, keyword cut by underscore,
		// comma, and a lone point followed by a non-digit
		send_byte(8'h00);
		send_text("(b8_q,.");
		send_byte(8'hFF);
		send_end(8'hA5);
		// number ended by a second point, lone point, then unterminated block comment
		send_text("1.2./* ");
		send_end(8'h00);
		// single-quoted string holding a double quote, lone slash before a word
		send_text("'a\"'/a");
		send_end(8'hFF);
		// line comment then unterminated string
		send_text("// c\n\"ab");
		send_end(8'h5A);
		// end of input on an empty text
		send_end(8'h3C);
		send_text("muat(");
		send_end(8'h81);
	endtask

	task automatic test_random_text(int count);
		int first;
		first = items_sent;
		while (items_sent - first < count)
			send_fragment();
		send_end(8'($urandom_range(0, 255)));
	endtask

	// The sender holds off until every predicted token has come out.
	task automatic test_drain_pause();
		repeat (6) begin
			repeat (3) send_fragment();
			wait_for_drain();
		end
	endtask

	// Token side pacing: random stalls while idling is on, always ready otherwise.
	initial begin : sink_pacing
		int hold;
		tok_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = pick_gap();
			if (hold > 0) begin
				tok_ready = 1'b0;
				repeat (hold) @(negedge clk);
			end
			tok_ready = 1'b1;
			hold = $urandom_range(1, 8);
			repeat (hold) @(negedge clk);
		end
	end

	// Output checker: each token transfer against the oldest prediction.
	always @(posedge clk) begin
		tok_item_t want;
		if (arst_n && tok_valid && tok_ready) begin
			tokens_checked++;
			if (expected_tokens.size() == 0) begin
				$error("unexpected token: kind %0d start %0d end %0d",
					tok_item.token_kind, tok_item.start_offset, tok_item.end_offset);
				failures++;
			end else begin
				want = expected_tokens.pop_front();
				if (tok_item.token_kind !== want.token_kind) begin
					$error("token_kind: expected %0d, got %0d",
						want.token_kind, tok_item.token_kind);
					failures++;
				end
				if (tok_item.start_offset !== want.start_offset) begin
					$error("start_offset: expected %0d, got %0d",
						want.start_offset, tok_item.start_offset);
					failures++;
				end
				if (tok_item.end_offset !== want.end_offset) begin
					$error("end_offset: expected %0d, got %0d",
						want.end_offset, tok_item.end_offset);
					failures++;
				end
				if (tok_item.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, tok_item.last);
					failures++;
				end
			end
		end
	end

	// Hang detector: counts cycles with no transfer on either channel.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((src_valid && src_ready) || (tok_valid && tok_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT)
				break;
		end
		$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin : main_sequence
		src_valid      = 1'b0;
		src_item       = '0;
		arst_n         = 1'b0;
		idle_on        = 1'b1;
		failures       = 0;
		items_sent     = 0;
		tokens_checked = 0;
		texts_ended    = 0;
		lexer_clear();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_text(280);
		test_drain_pause();
		// back-to-back stretch: no source gaps, token side always ready
		idle_on = 1'b0;
		test_random_text(120);
		idle_on = 1'b1;
		test_random_text(240);

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d source items over %0d texts, %0d tokens compared.",
			items_sent, texts_ended, tokens_checked);
		$display("Keywords, strings, numbers, comments, noise bytes and stalls all exercised.");
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
